// ===== rtl/pen_pkg.sv =====
package pen_pkg;

	// Message kinds on the input side.
	localparam logic [1:0] MSG_START = 2'd0;
	localparam logic [1:0] MSG_PROBE = 2'd1;
	localparam logic [1:0] MSG_ECHO  = 2'd2;
	localparam logic [1:0] MSG_EMPTY = 2'd3;

	// Result kinds on the output side.
	localparam logic [1:0] OUT_PROBE    = 2'd0;
	localparam logic [1:0] OUT_ECHO     = 2'd1;
	localparam logic [1:0] OUT_EMPTY    = 2'd2;
	localparam logic [1:0] OUT_COMPLETE = 2'd3;

	// Configuration register indexes.
	localparam int CFG_INDEX_W = 1;
	localparam logic [CFG_INDEX_W-1:0] CFG_NODE_ID       = 1'd0;
	localparam logic [CFG_INDEX_W-1:0] CFG_NEIGHBOR_MASK = 1'd1;

	// Stream field layout.
	localparam int TDATA_W   = 32;
	localparam int KIND_W    = 2;
	localparam int NODE_W    = 4;
	localparam int ROW_W     = 16;
	localparam int PENDING_W = 5;
	localparam int KIND_LSB  = 0;
	localparam int NODE_LSB  = 2;
	localparam int RIDX_LSB  = 6;
	localparam int ROW_LSB   = 10;

	typedef enum logic [1:0] {
		PH_IDLE,
		PH_WAIT,
		PH_COLLECT,
		PH_DONE
	} phase_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_OR,
		ST_ACT,
		ST_CLR,
		ST_DEC,
		ST_PROBE,
		ST_FIN,
		ST_ECHO_RD,
		ST_ECHO
	} step_t;

endpackage

// ===== rtl/pen_topo_ram.sv =====
module pen_topo_ram #(
	parameter int LIVE = 16
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    clear,
	input  logic                    we,
	input  logic [$clog2(LIVE)-1:0] waddr,
	input  logic [LIVE-1:0]         wdata,
	input  logic                    re,
	input  logic [$clog2(LIVE)-1:0] raddr,
	output logic [LIVE-1:0]         rdata
);

	logic [LIVE-1:0] mem [LIVE];
	logic [LIVE-1:0] valid_q;
	logic [LIVE-1:0] rdata_q;
	logic            rvalid_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	// A start clears every row at once; a write in the same cycle still lands.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			rvalid_q <= 1'b0;
		end else begin
			if (clear) begin
				valid_q <= we ? (LIVE'(1) << waddr) : '0;
			end else if (we) begin
				valid_q[waddr] <= 1'b1;
			end
			if (re) begin
				rvalid_q <= valid_q[raddr];
			end
		end
	end

	assign rdata = rvalid_q ? rdata_q : '0;

endmodule

// ===== rtl/probe_echo_topology_node_core.sv =====
// A row item that is merged into the matrix has its row read from the topology memory
// and written back; the last row of a message then passes the ACT step, and CLR or DEC
// where needed, before its results go out. Probes leave one per cycle while the output
// is not stalled; an echo reads each row from the topology memory before it sends it.
// One item is worked on at a time; the input waits while results are being sent.
// Reset (arst_n low, asynchronous) returns the node to idle with its control registers at
// zero and all matrix rows reading zero; no clearing pass is needed.
module probe_echo_topology_node_core #(
	parameter int NODES = 16
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pen_pkg::CFG_INDEX_W-1:0] cfg_index,
	input  logic [pen_pkg::ROW_W-1:0]       cfg_wdata,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	// msg_kind[1:0], source_node[5:2], row_index[9:6], row_bits[25:10], zeros above
	input  logic [pen_pkg::TDATA_W-1:0]     s_axis_tdata,
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// out_kind[1:0], dest_node[5:2], out_row_index[9:6], out_row[25:10], zeros above
	output logic [pen_pkg::TDATA_W-1:0]     m_axis_tdata,
	output logic                           m_axis_tlast
);

	localparam int LIVE = (NODES > 16) ? 16 : NODES;
	localparam int AW = $clog2(LIVE);
	localparam logic [4:0] LIVE_W5 = 5'(LIVE);
	localparam logic [AW-1:0] LAST_ROW = AW'(LIVE - 1);

	// Configuration.
	logic [pen_pkg::NODE_W-1:0] node_id_q;
	logic [pen_pkg::ROW_W-1:0]  nmask_q;

	// Protocol state.
	pen_pkg::phase_t              phase_q, phase_n;
	pen_pkg::step_t               step_q, step_n;
	logic [pen_pkg::NODE_W-1:0]    parent_q, parent_n;
	logic [pen_pkg::PENDING_W-1:0] pending_q, pending_n;
	logic [LIVE-1:0]               pmask_q, pmask_n;
	logic [AW-1:0]                 k_q, k_n;

	// Item being worked on.
	logic [pen_pkg::KIND_W-1:0] kind_q;
	logic [pen_pkg::NODE_W-1:0] src_q;
	logic [pen_pkg::NODE_W-1:0] ridx_q;
	logic [LIVE-1:0]            bits_q;
	logic                       last_q;

	// Output register.
	logic                       out_valid_q;
	logic [pen_pkg::KIND_W-1:0] out_kind_q;
	logic [pen_pkg::NODE_W-1:0] out_dest_q;
	logic [pen_pkg::NODE_W-1:0] out_ridx_q;
	logic [pen_pkg::ROW_W-1:0]  out_row_q;
	logic                       out_last_q;

	logic                       emit;
	logic [pen_pkg::KIND_W-1:0] emit_kind;
	logic [pen_pkg::NODE_W-1:0] emit_dest;
	logic [pen_pkg::NODE_W-1:0] emit_ridx;
	logic [pen_pkg::ROW_W-1:0]  emit_row;
	logic                       emit_last;

	// Memory port.
	logic            ram_clear, ram_we, ram_re;
	logic [AW-1:0]   ram_waddr, ram_raddr;
	logic [LIVE-1:0] ram_wdata, ram_rdata;

	logic                       accept;
	logic                       slot_free;
	logic [pen_pkg::KIND_W-1:0] in_kind;
	logic [pen_pkg::NODE_W-1:0] in_ridx;
	logic [LIVE-1:0]            nmask_live;
	logic                       node_live;
	logic                       in_ridx_live;
	logic [AW-1:0]              low_idx;
	logic [LIVE-1:0]            pmask_rest;
	logic [pen_pkg::PENDING_W-1:0] pend_dec;

	assign in_kind = s_axis_tdata[pen_pkg::KIND_LSB +: pen_pkg::KIND_W];
	assign in_ridx = s_axis_tdata[pen_pkg::RIDX_LSB +: pen_pkg::NODE_W];
	assign nmask_live = nmask_q[LIVE-1:0];
	assign node_live = {1'b0, node_id_q} < LIVE_W5;
	assign in_ridx_live = {1'b0, in_ridx} < LIVE_W5;

	assign s_axis_tready = (step_q == pen_pkg::ST_IDLE);
	assign accept = s_axis_tvalid && s_axis_tready;
	assign slot_free = !out_valid_q || m_axis_tready;

	// Lowest neighbor still to be probed.
	always_comb begin
		low_idx = '0;
		for (int i = LIVE - 1; i >= 0; i--) begin
			if (pmask_q[i]) begin
				low_idx = AW'(i);
			end
		end
	end

	assign pmask_rest = pmask_q & ~(LIVE'(1) << low_idx);
	assign pend_dec = (pending_q == '0) ? '0 : pending_q - 5'd1;

	always_comb begin
		phase_n   = phase_q;
		step_n    = step_q;
		parent_n  = parent_q;
		pending_n = pending_q;
		pmask_n   = pmask_q;
		k_n       = k_q;
		ram_clear = 1'b0;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		emit      = 1'b0;
		emit_kind = pen_pkg::OUT_PROBE;
		emit_dest = '0;
		emit_ridx = '0;
		emit_row  = '0;
		emit_last = 1'b0;

		unique case (step_q)
			pen_pkg::ST_IDLE: begin
				if (accept) begin
					if (in_kind == pen_pkg::MSG_START) begin
						ram_clear = 1'b1;
						if (node_live) begin
							ram_we    = 1'b1;
							ram_waddr = node_id_q[AW-1:0];
							ram_wdata = nmask_live;
						end
						parent_n  = '0;
						pending_n = '0;
						if (node_id_q == '0) begin
							phase_n = pen_pkg::PH_COLLECT;
							pmask_n = nmask_live;
							step_n  = pen_pkg::ST_PROBE;
						end else begin
							phase_n = pen_pkg::PH_WAIT;
						end
					end else if (phase_q == pen_pkg::PH_WAIT ||
							phase_q == pen_pkg::PH_COLLECT) begin
						if (in_ridx_live) begin
							ram_re    = 1'b1;
							ram_raddr = in_ridx[AW-1:0];
							step_n    = pen_pkg::ST_OR;
						end else if (s_axis_tlast) begin
							step_n = pen_pkg::ST_ACT;
						end
					end
				end
			end
			pen_pkg::ST_OR: begin
				ram_we    = 1'b1;
				ram_waddr = ridx_q[AW-1:0];
				ram_wdata = ram_rdata | bits_q;
				step_n    = last_q ? pen_pkg::ST_ACT : pen_pkg::ST_IDLE;
			end
			pen_pkg::ST_ACT: begin
				priority if (phase_q == pen_pkg::PH_WAIT) begin
					// The first message names the parent, which is not probed.
					parent_n  = src_q;
					pmask_n   = nmask_live & ~(LIVE'(1) << src_q);
					pending_n = '0;
					phase_n   = pen_pkg::PH_COLLECT;
					step_n    = pen_pkg::ST_PROBE;
				end else if (kind_q == pen_pkg::MSG_PROBE) begin
					if (slot_free) begin
						emit      = 1'b1;
						emit_kind = pen_pkg::OUT_EMPTY;
						emit_dest = src_q;
						emit_last = 1'b1;
						step_n    = pen_pkg::ST_IDLE;
					end
				end else if (kind_q == pen_pkg::MSG_EMPTY && node_live) begin
					ram_re    = 1'b1;
					ram_raddr = node_id_q[AW-1:0];
					step_n    = pen_pkg::ST_CLR;
				end else begin
					step_n = pen_pkg::ST_DEC;
				end
			end
			pen_pkg::ST_CLR: begin
				// An empty echo means the sender is a child elsewhere, not a tree link.
				ram_we    = 1'b1;
				ram_waddr = node_id_q[AW-1:0];
				ram_wdata = ram_rdata & ~(LIVE'(1) << src_q);
				step_n    = pen_pkg::ST_DEC;
			end
			pen_pkg::ST_DEC: begin
				pending_n = pend_dec;
				step_n    = (pend_dec == '0) ? pen_pkg::ST_FIN : pen_pkg::ST_IDLE;
			end
			pen_pkg::ST_PROBE: begin
				if (pmask_q == '0) begin
					step_n = (pending_q == '0) ? pen_pkg::ST_FIN : pen_pkg::ST_IDLE;
				end else if (slot_free) begin
					emit      = 1'b1;
					emit_kind = pen_pkg::OUT_PROBE;
					emit_dest = pen_pkg::NODE_W'(low_idx);
					emit_last = (pmask_rest == '0);
					pmask_n   = pmask_rest;
					pending_n = pending_q + 5'd1;
				end
			end
			pen_pkg::ST_FIN: begin
				if (node_id_q == '0) begin
					if (slot_free) begin
						emit      = 1'b1;
						emit_kind = pen_pkg::OUT_COMPLETE;
						emit_dest = node_id_q;
						emit_last = 1'b1;
						phase_n   = pen_pkg::PH_DONE;
						step_n    = pen_pkg::ST_IDLE;
					end
				end else begin
					k_n    = '0;
					step_n = pen_pkg::ST_ECHO_RD;
				end
			end
			pen_pkg::ST_ECHO_RD: begin
				ram_re    = 1'b1;
				ram_raddr = k_q;
				step_n    = pen_pkg::ST_ECHO;
			end
			pen_pkg::ST_ECHO: begin
				// Read data holds while the output stalls: no other read is issued here.
				if (slot_free) begin
					emit      = 1'b1;
					emit_kind = pen_pkg::OUT_ECHO;
					emit_dest = parent_q;
					emit_ridx = pen_pkg::NODE_W'(k_q);
					emit_row  = pen_pkg::ROW_W'(ram_rdata);
					emit_last = (k_q == LAST_ROW);
					if (k_q == LAST_ROW) begin
						phase_n = pen_pkg::PH_DONE;
						step_n  = pen_pkg::ST_IDLE;
					end else begin
						k_n    = k_q + AW'(1);
						step_n = pen_pkg::ST_ECHO_RD;
					end
				end
			end
			default: begin
				step_n = pen_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q   <= '0;
			nmask_q     <= '0;
			phase_q     <= pen_pkg::PH_IDLE;
			step_q      <= pen_pkg::ST_IDLE;
			parent_q    <= '0;
			pending_q   <= '0;
			pmask_q     <= '0;
			k_q         <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					pen_pkg::CFG_NODE_ID:       node_id_q <= cfg_wdata[pen_pkg::NODE_W-1:0];
					pen_pkg::CFG_NEIGHBOR_MASK: nmask_q   <= cfg_wdata;
					default: ;
				endcase
			end
			phase_q   <= phase_n;
			step_q    <= step_n;
			parent_q  <= parent_n;
			pending_q <= pending_n;
			pmask_q   <= pmask_n;
			k_q       <= k_n;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (m_axis_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= in_kind;
			src_q  <= s_axis_tdata[pen_pkg::NODE_LSB +: pen_pkg::NODE_W];
			ridx_q <= in_ridx;
			bits_q <= s_axis_tdata[pen_pkg::ROW_LSB +: LIVE];
			last_q <= s_axis_tlast;
		end
		if (emit) begin
			out_kind_q <= emit_kind;
			out_dest_q <= emit_dest;
			out_ridx_q <= emit_ridx;
			out_row_q  <= emit_row;
			out_last_q <= emit_last;
		end
	end

	pen_topo_ram #(
		.LIVE(LIVE)
	) u_topo_ram (
		.clk   (clk),
		.arst_n(arst_n),
		.clear (ram_clear),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {6'd0, out_row_q, out_ridx_q, out_dest_q, out_kind_q};

endmodule

// ===== dv/probe_echo_topology_node_checker.sv =====
module probe_echo_topology_node_checker
	import pen_pkg::*;
(
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   cfg_we,
	input  logic [CFG_INDEX_W-1:0] cfg_index,
	input  logic [ROW_W-1:0]       cfg_wdata,
	input  logic                   s_axis_tvalid,
	input  logic                   s_axis_tready,
	// msg_kind[1:0], source_node[5:2], row_index[9:6], row_bits[25:10], zeros above
	input  logic [TDATA_W-1:0]     s_axis_tdata,
	input  logic                   s_axis_tlast,
	input  logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	// out_kind[1:0], dest_node[5:2], out_row_index[9:6], out_row[25:10], zeros above
	input  logic [TDATA_W-1:0]     m_axis_tdata,
	input  logic                   m_axis_tlast,
	output int                     fail_count,
	output int                     expected_left
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [NODE_W-1:0] dest;
		logic [NODE_W-1:0] ridx;
		logic [ROW_W-1:0]  row;
		logic              last;
	} out_msg_t;

	out_msg_t outbound[$];
	int mismatches = 0;

	// Node state as the protocol sees it.
	phase_t           node_phase = PH_IDLE;
	logic [3:0]       node_id_q = '0;
	logic [ROW_W-1:0] nmask_q = '0;
	logic [3:0]       parent_q = '0;
	logic [4:0]       answers_due = '0;
	logic [ROW_W-1:0] topo [16];

	// The newest message of a step is held back so that it can take the last flag.
	out_msg_t held;
	bit       have_held = 1'b0;

	initial begin
		for (int k = 0; k < 16; k++)
			topo[k] = '0;
	end

	task automatic report(input string msg);
		$display("[%0t] mismatch: %s", $realtime, msg);
		mismatches++;
	endtask

	function void emit(input logic [1:0] kind, input logic [3:0] dest,
			input logic [3:0] ridx, input logic [ROW_W-1:0] row);
		if (have_held)
			outbound.push_back(held);
		held.kind = kind;
		held.dest = dest;
		held.ridx = ridx;
		held.row = row;
		held.last = 1'b0;
		have_held = 1'b1;
	endfunction

	function void fan_out(input logic [ROW_W-1:0] mask);
		answers_due = '0;
		for (int j = 0; j < 16; j++) begin
			if (mask[j]) begin
				emit(OUT_PROBE, 4'(j), 4'd0, '0);
				answers_due++;
			end
		end
	endfunction

	function void wrap_up();
		if (node_id_q == 4'd0) begin
			emit(OUT_COMPLETE, node_id_q, 4'd0, '0);
		end else begin
			for (int k = 0; k < 16; k++)
				emit(OUT_ECHO, parent_q, 4'(k), topo[k]);
		end
		node_phase = PH_DONE;
	endfunction

	function void advance_node(input logic [1:0] kind, input logic [3:0] src,
			input logic [3:0] ridx, input logic [ROW_W-1:0] bits, input logic last);
		if (kind == MSG_START) begin
			for (int k = 0; k < 16; k++)
				topo[k] = '0;
			topo[node_id_q] = nmask_q;
			parent_q = '0;
			answers_due = '0;
			if (node_id_q == 4'd0) begin
				fan_out(nmask_q);
				node_phase = PH_COLLECT;
				if (answers_due == 0)
					wrap_up();
			end else begin
				node_phase = PH_WAIT;
			end
		end else if (node_phase == PH_WAIT || node_phase == PH_COLLECT) begin
			topo[ridx] |= bits;
			if (last) begin
				if (node_phase == PH_WAIT) begin
					// The first complete message adopts its sender as parent.
					parent_q = src;
					fan_out(nmask_q & ~(16'd1 << src));
					node_phase = PH_COLLECT;
					if (answers_due == 0)
						wrap_up();
				end else if (kind == MSG_PROBE) begin
					emit(OUT_EMPTY, src, 4'd0, '0);
				end else begin
					if (kind == MSG_EMPTY)
						topo[node_id_q][src] = 1'b0;
					if (answers_due != 0)
						answers_due--;
					if (answers_due == 0)
						wrap_up();
				end
			end
		end
		if (have_held) begin
			held.last = 1'b1;
			outbound.push_back(held);
			have_held = 1'b0;
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		out_msg_t seen;
		out_msg_t want;
		if (!arst_n) begin
			outbound.delete();
			node_phase = PH_IDLE;
			node_id_q = '0;
			nmask_q = '0;
			parent_q = '0;
			answers_due = '0;
			for (int k = 0; k < 16; k++)
				topo[k] = '0;
			expected_left <= 0;
		end else begin
			// A result at this edge cannot stem from an input taken at the same edge.
			if (m_axis_tvalid && m_axis_tready) begin
				seen.kind = m_axis_tdata[KIND_LSB +: KIND_W];
				seen.dest = m_axis_tdata[NODE_LSB +: NODE_W];
				seen.ridx = m_axis_tdata[RIDX_LSB +: NODE_W];
				seen.row = m_axis_tdata[ROW_LSB +: ROW_W];
				seen.last = m_axis_tlast;
				if (outbound.size() == 0) begin
					report($sformatf("result kind %0d dest %0d row %0d with nothing outstanding",
						seen.kind, seen.dest, seen.ridx));
				end else begin
					want = outbound.pop_front();
					if (seen.kind != want.kind)
						report($sformatf("out_kind %0d, expected %0d", seen.kind, want.kind));
					if (seen.dest != want.dest)
						report($sformatf("dest_node %0d, expected %0d", seen.dest, want.dest));
					if (seen.ridx != want.ridx)
						report($sformatf("out_row_index %0d, expected %0d",
							seen.ridx, want.ridx));
					if (seen.row != want.row)
						report($sformatf("out_row %h, expected %h", seen.row, want.row));
					if (seen.last != want.last)
						report($sformatf("out_last %0b, expected %0b", seen.last, want.last));
				end
			end
			if (s_axis_tvalid && s_axis_tready)
				advance_node(s_axis_tdata[KIND_LSB +: KIND_W],
					s_axis_tdata[NODE_LSB +: NODE_W],
					s_axis_tdata[RIDX_LSB +: NODE_W],
					s_axis_tdata[ROW_LSB +: ROW_W], s_axis_tlast);
			if (cfg_we) begin
				if (cfg_index == CFG_NODE_ID)
					node_id_q = cfg_wdata[3:0];
				else if (cfg_index == CFG_NEIGHBOR_MASK)
					nmask_q = cfg_wdata;
			end
			expected_left <= outbound.size();
		end
		fail_count <= mismatches;
	end

endmodule

// ===== dv/probe_echo_topology_node_core_test.sv =====
module probe_echo_topology_node_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	import pen_pkg::*;

	logic                   clk;
	logic                   arst_n;
	logic                   cfg_we;
	logic [CFG_INDEX_W-1:0] cfg_index;
	logic [ROW_W-1:0]       cfg_wdata;
	logic                   s_axis_tvalid;
	logic                   s_axis_tready;
	// msg_kind[1:0], source_node[5:2], row_index[9:6], row_bits[25:10], zeros above
	logic [TDATA_W-1:0]     s_axis_tdata;
	logic                   s_axis_tlast;
	logic                   m_axis_tvalid;
	logic                   m_axis_tready;
	// out_kind[1:0], dest_node[5:2], out_row_index[9:6], out_row[25:10], zeros above
	logic [TDATA_W-1:0]     m_axis_tdata;
	logic                   m_axis_tlast;

	int fail_count;
	int expected_left;
	int beats_sent = 0;
	int tx_idle_pct = 0;
	int rx_stall_pct = 0;

	probe_echo_topology_node_core u_top (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_wdata,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tlast,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.m_axis_tlast
	);

	probe_echo_topology_node_checker u_check (
		.clk,
		.arst_n,
		.cfg_we,
		.cfg_index,
		.cfg_wdata,
		.s_axis_tvalid,
		.s_axis_tready,
		.s_axis_tdata,
		.s_axis_tlast,
		.m_axis_tvalid,
		.m_axis_tready,
		.m_axis_tdata,
		.m_axis_tlast,
		.fail_count,
		.expected_left
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#2_000_000;
		$display("FAILURE");
		$finish;
	end

	initial begin
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
		end
	end

	task automatic send_beat(input logic [1:0] kind, input logic [3:0] src,
			input logic [3:0] ridx, input logic [ROW_W-1:0] bits, input logic last);
		@(negedge clk);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {6'd0, bits, ridx, src, kind};
		s_axis_tlast <= last;
		do
			@(posedge clk);
		while (!s_axis_tready);
		beats_sent++;
	endtask

	task automatic send_msg(input logic [1:0] kind, input logic [3:0] src, input int nrows);
		for (int r = 0; r < nrows; r++)
			send_beat(kind, src, 4'($urandom_range(15)), 16'($urandom), r == nrows - 1);
	endtask

	// Stops the sender until every predicted result is out and the node has settled.
	task automatic hold_off();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic write_cfg(input logic [CFG_INDEX_W-1:0] idx, input logic [ROW_W-1:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// One protocol round: start, adopt a parent where not root, then answer every probe.
	task automatic run_round(input logic [3:0] id, input logic [ROW_W-1:0] mask);
		logic [ROW_W-1:0] probed;
		logic [3:0]       parent;
		logic [3:0]       src;
		int               due;
		int               got;
		int               pick;
		hold_off();
		write_cfg(CFG_NODE_ID, {12'd0, id});
		write_cfg(CFG_NEIGHBOR_MASK, mask);
		send_beat(MSG_START, 4'($urandom), 4'($urandom), 16'($urandom), 1'($urandom));
		probed = mask;
		if (id != 4'd0) begin
			parent = 4'($urandom_range(15));
			send_msg(2'($urandom_range(1, 3)), parent, $urandom_range(1, 3));
			probed = mask & ~(16'd1 << parent);
		end
		due = $countones(probed);
		got = 0;
		while (got < due) begin
			pick = $urandom_range(99);
			if (pick < 2) begin
				send_beat(MSG_START, 4'($urandom), 4'($urandom), 16'($urandom), 1'b1);
			end else if (pick < 17) begin
				send_msg(MSG_PROBE, 4'($urandom_range(15)), $urandom_range(1, 2));
			end else if (pick < 22) begin
				send_beat(2'($urandom_range(1, 3)), 4'($urandom), 4'($urandom),
					16'($urandom), 1'($urandom));
			end else begin
				do
					src = 4'($urandom_range(15));
				while (!probed[src]);
				send_msg(pick < 60 ? MSG_ECHO : MSG_EMPTY, src, $urandom_range(1, 3));
				got++;
			end
		end
		if ($urandom_range(3) == 0)
			send_msg(2'($urandom_range(1, 3)), 4'($urandom_range(15)), 1);
	endtask

	function automatic logic [ROW_W-1:0] pick_mask();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 16'hFFFF;
		if (r == 1)
			return 16'h0000;
		if (r < 6)
			return 16'($urandom & $urandom & $urandom);
		return 16'($urandom & $urandom);
	endfunction

	initial begin
		int target;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		repeat (8) @(negedge clk);
		arst_n = 1'b1;

		// Idle node ignores messages; root with no neighbors completes at once,
		// even on a start whose last flag is low and whose row fields are full.
		send_beat(MSG_PROBE, 4'd1, 4'd2, 16'h1234, 1'b1);
		send_beat(MSG_START, 4'hF, 4'hF, 16'hFFFF, 1'b0);
		send_beat(MSG_ECHO, 4'd9, 4'd3, 16'hFFFF, 1'b1);

		// Highest node, fully linked: a two-row echo names the parent, fifteen probes
		// go out, a probe gets an empty echo, and a start restarts mid-collection.
		hold_off();
		write_cfg(CFG_NODE_ID, 16'd15);
		write_cfg(CFG_NEIGHBOR_MASK, 16'hFFFF);
		send_beat(MSG_PROBE, 4'd0, 4'd0, 16'h0000, 1'b1);
		send_beat(MSG_START, 4'd0, 4'd0, 16'h0000, 1'b1);
		send_beat(MSG_ECHO, 4'd0, 4'd15, 16'hFFFF, 1'b0);
		send_beat(MSG_ECHO, 4'd0, 4'd0, 16'h8001, 1'b1);
		send_beat(MSG_PROBE, 4'd15, 4'd0, 16'h0000, 1'b1);
		send_beat(MSG_EMPTY, 4'd3, 4'd5, 16'h0F0F, 1'b1);
		send_beat(MSG_START, 4'd6, 4'd6, 16'hAAAA, 1'b1);

		// Leaf whose only neighbor is its parent echoes the whole matrix at once.
		hold_off();
		write_cfg(CFG_NODE_ID, 16'd7);
		write_cfg(CFG_NEIGHBOR_MASK, 16'h0004);
		send_beat(MSG_START, 4'd0, 4'd0, 16'h0000, 1'b1);
		send_beat(MSG_PROBE, 4'd2, 4'd9, 16'h5555, 1'b1);
		send_beat(MSG_EMPTY, 4'd2, 4'd0, 16'h0000, 1'b1);

		// Root linked to itself and node 1: echo, a stray probe, then an empty echo.
		hold_off();
		write_cfg(CFG_NODE_ID, 16'd0);
		write_cfg(CFG_NEIGHBOR_MASK, 16'h0003);
		send_beat(MSG_START, 4'd0, 4'd0, 16'h0000, 1'b1);
		send_beat(MSG_ECHO, 4'd1, 4'd1, 16'h0001, 1'b0);
		send_beat(MSG_ECHO, 4'd1, 4'd2, 16'h00F0, 1'b1);
		send_beat(MSG_PROBE, 4'd5, 4'd0, 16'h0000, 1'b1);
		send_beat(MSG_EMPTY, 4'd0, 4'd0, 16'h0000, 1'b1);

		for (int p = 0; p < 4; p++) begin
			hold_off();
			case (p)
				0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
				1: begin tx_idle_pct = 70; rx_stall_pct = 0;  end
				2: begin tx_idle_pct = 0;  rx_stall_pct = 70; end
				default: begin tx_idle_pct = 8; rx_stall_pct = 8; end
			endcase
			target = beats_sent + 44;
			while (beats_sent < target)
				run_round(($urandom_range(2) == 0) ? 4'd0 : 4'($urandom_range(1, 15)),
					pick_mask());
		end

		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		@(posedge clk);
		while (expected_left != 0)
			@(posedge clk);
		repeat (40) @(posedge clk);
		if (fail_count == 0 && expected_left == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule
